[src/rrs_pkg.sv]
// Round-robin slice scheduler: shared widths, status codes, job table entry and result types.
// No dependencies; compiled first.
`default_nettype none

package rrs_pkg;

  localparam int ARR_W  = 16;
  localparam int LEN_W  = 16;
  localparam int TIME_W = 24;
  localparam int ID_W   = 6;
  localparam int STAT_W = 2;

  localparam logic OP_LOAD = 1'b0;

  localparam logic [STAT_W-1:0] ST_LOADED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [STAT_W-1:0] ST_RAN     = 2'd2;
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd3;

  typedef struct packed {
    logic [ARR_W-1:0]  arrival;
    logic [LEN_W-1:0]  remaining;
    logic [LEN_W-1:0]  orig_len;
    logic [ID_W-1:0]   ident;
    logic [TIME_W-1:0] first_start;
    logic              started;
  } job_ent_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] start_time;
    logic [LEN_W-1:0]  run_length;
    logic              finished;
    logic [TIME_W-1:0] resp_lat;
    logic [TIME_W-1:0] turn_lat;
    logic [TIME_W-1:0] wait_lat;
  } res_t;

endpackage

`default_nettype wire

[src/rrs_cfg_if.sv]
// Configuration write channel of the scheduler: valid/ready plus the time slice value.
// Depends on rrs_pkg.
`default_nettype none

interface rrs_cfg_if;
  import rrs_pkg::*;

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/rrs_in_if.sv]
// Input item channel of the scheduler: valid/ready plus operation, arrival and length.
// Depends on rrs_pkg.
`default_nettype none

interface rrs_in_if;
  import rrs_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [ARR_W-1:0] arrival;
  logic [LEN_W-1:0] length;

  modport source (output valid, output operation, output arrival, output length, input ready);
  modport sink   (input valid, input operation, input arrival, input length, output ready);
endinterface

`default_nettype wire

[src/rrs_out_if.sv]
// Result channel of the scheduler: valid/ready plus the per-beat report fields.
// Depends on rrs_pkg.
`default_nettype none

interface rrs_out_if;
  import rrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   job_id;
  logic [TIME_W-1:0] start_time;
  logic [LEN_W-1:0]  run_length;
  logic              finished;
  logic [TIME_W-1:0] resp_lat;
  logic [TIME_W-1:0] turn_lat;
  logic [TIME_W-1:0] wait_lat;

  modport source (output valid, output status, output job_id, output start_time,
                  output run_length, output finished, output resp_lat,
                  output turn_lat, output wait_lat, input ready);
  modport sink   (input valid, input status, input job_id, input start_time,
                  input run_length, input finished, input resp_lat,
                  input turn_lat, input wait_lat, output ready);
endinterface

`default_nettype wire

[src/round_robin_slice_scheduler_unit.sv]
// Top level of the round-robin time-slice scheduler: control sequencer around the job table RAM.
// Depends on rrs_pkg, rrs_cfg_if, rrs_in_if, rrs_out_if and rrs_job_ram.
//
// The block keeps up to MAX_JOBS jobs in one single-port-style RAM (one read, one write per
// cycle, read data registered), sorted by arrival; equal arrivals keep load order, and job
// ids count loads. A load beat (operation 0) walks the table from its last entry toward slot
// 0, moving each later job up one slot until the insertion point is found. Zero length or a
// full table is refused at once. A step beat (operation 1) runs the next round-robin slice of
// min(time_slice, remaining) units: the sequencer reads one entry at a time from the scan
// position, wrapping into new rounds, and when a full round runs nothing it searches from the
// top for the first unfinished job and jumps time to its arrival. A step may visit the rest
// of a round, one idle round, the search and the round that runs; a step with nothing left
// answers with status 3. One item is in work at a time; the next item is taken as soon as
// the previous result sits in the output register, even if that result is not yet taken.
// Table entries need no clearing after reset: only entries below the load count are ever
// read. time_slice may be written at any idle time; a value of 0 runs as 1. Times wrap
// modulo 2^24.
`default_nettype none

module round_robin_slice_scheduler_unit #(
  parameter int MAX_JOBS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  rrs_cfg_if.sink   cfg_bus,
  rrs_in_if.sink    in_bus,
  rrs_out_if.source out_bus
);
  import rrs_pkg::*;

  localparam int IW = $clog2(MAX_JOBS);      // table index
  localparam int CW = $clog2(MAX_JOBS + 1);  // counts up to MAX_JOBS

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LD_RD  = 9'b000000010,  // load: read entry below k, or drop the new job into slot 0
    S_LD_WR  = 9'b000000100,  // load: shift it up or drop the new job in
    S_RUN_RD = 9'b000001000,  // step: read entry at scan position / round end
    S_RUN_EV = 9'b000010000,  // step: check eligibility, run the slice
    S_JMP_RD = 9'b000100000,  // idle round: read entry k
    S_JMP_EV = 9'b001000000,  // idle round: first unfinished sets time
    S_MET    = 9'b010000000,  // completion metrics
    S_OUT    = 9'b100000000   // hand result to output register
  } state_t;

  // control state
  state_t            state_r,     state_nxt;
  logic [CW-1:0]     loaded_r,    loaded_nxt;
  logic [CW-1:0]     finished_r,  finished_nxt;
  logic [TIME_W-1:0] time_r,      time_nxt;
  logic [CW-1:0]     sp_r,        sp_nxt;
  logic              ran_r,       ran_nxt;
  logic [LEN_W-1:0]  tslice_r,    tslice_nxt;
  logic [CW-1:0]     k_r,         k_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [ARR_W-1:0]  ld_arr_r,    ld_arr_nxt;
  logic [LEN_W-1:0]  ld_len_r,    ld_len_nxt;
  job_ent_t          ent_r,       ent_nxt;
  res_t              res_r,       res_nxt;
  res_t              out_res_r,   out_res_nxt;

  // job RAM port
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  job_ent_t          ram_wdata;
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  job_ent_t          ram_rdata;

  rrs_job_ram #(.DEPTH(MAX_JOBS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // slice arithmetic on the entry just read
  logic [LEN_W-1:0]  quantum;
  logic              run_hit;
  logic [LEN_W-1:0]  run_len;
  logic [LEN_W-1:0]  rem_new;
  job_ent_t          upd_ent;
  job_ent_t          new_ent;
  logic [CW-1:0]     k_dec;
  logic [TIME_W-1:0] met_turn;

  assign quantum = (tslice_r == '0) ? LEN_W'(1) : tslice_r;
  assign run_hit = (TIME_W'(ram_rdata.arrival) <= time_r) && (ram_rdata.remaining != '0);
  assign run_len = (ram_rdata.remaining > quantum) ? quantum : ram_rdata.remaining;
  assign rem_new = ram_rdata.remaining - run_len;

  always_comb begin
    upd_ent           = ram_rdata;
    upd_ent.remaining = rem_new;
    upd_ent.started   = 1'b1;
    if (!ram_rdata.started) begin
      upd_ent.first_start = time_r;
    end
  end

  always_comb begin
    new_ent             = '0;
    new_ent.arrival     = ld_arr_r;
    new_ent.remaining   = ld_len_r;
    new_ent.orig_len    = ld_len_r;
    new_ent.ident       = ID_W'(loaded_r);
  end

  assign k_dec    = k_r - CW'(1);
  assign met_turn = time_r - TIME_W'(ent_r.arrival);

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    finished_nxt  = finished_r;
    time_nxt      = time_r;
    sp_nxt        = sp_r;
    ran_nxt       = ran_r;
    tslice_nxt    = tslice_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    ld_arr_nxt    = ld_arr_r;
    ld_len_nxt    = ld_len_r;
    ent_nxt       = ent_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_waddr     = k_r[IW-1:0];
    ram_wdata     = new_ent;
    ram_re        = 1'b0;
    ram_raddr     = sp_r[IW-1:0];

    if (cfg_bus.valid) begin
      tslice_nxt = cfg_bus.data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          res_nxt = '0;
          if (in_bus.operation == OP_LOAD) begin
            ld_arr_nxt = in_bus.arrival;
            ld_len_nxt = in_bus.length;
            if (in_bus.length == '0 || loaded_r == CW'(MAX_JOBS)) begin
              res_nxt.status = ST_REFUSED;
              state_nxt      = S_OUT;
            end else begin
              res_nxt.status = ST_LOADED;
              res_nxt.job_id = ID_W'(loaded_r);
              k_nxt          = loaded_r;
              state_nxt      = S_LD_RD;
            end
          end else begin
            res_nxt.status     = ST_DONE;
            res_nxt.start_time = time_r;
            state_nxt          = (finished_r >= loaded_r) ? S_OUT : S_RUN_RD;
          end
        end
      end

      S_LD_RD: begin
        if (k_r == '0) begin
          ram_we     = 1'b1;
          ram_waddr  = '0;
          loaded_nxt = loaded_r + CW'(1);
          state_nxt  = S_OUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = k_dec[IW-1:0];
          state_nxt = S_LD_WR;
        end
      end

      S_LD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IW-1:0];
        if (ram_rdata.arrival > ld_arr_r) begin
          // later arrival moves up one slot
          ram_wdata = ram_rdata;
          k_nxt     = k_dec;
          state_nxt = S_LD_RD;
        end else begin
          loaded_nxt = loaded_r + CW'(1);
          state_nxt  = S_OUT;
        end
      end

      S_RUN_RD: begin
        if (sp_r >= loaded_r) begin
          // round end
          if (!ran_r) begin
            k_nxt     = '0;
            state_nxt = S_JMP_RD;
          end else begin
            sp_nxt  = '0;
            ran_nxt = 1'b0;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = sp_r[IW-1:0];
          state_nxt = S_RUN_EV;
        end
      end

      S_RUN_EV: begin
        sp_nxt = sp_r + CW'(1);
        if (run_hit) begin
          ram_we             = 1'b1;
          ram_waddr          = sp_r[IW-1:0];
          ram_wdata          = upd_ent;
          ent_nxt            = upd_ent;
          time_nxt           = time_r + TIME_W'(run_len);
          ran_nxt            = 1'b1;
          res_nxt.status     = ST_RAN;
          res_nxt.job_id     = ram_rdata.ident;
          res_nxt.start_time = time_r;
          res_nxt.run_length = run_len;
          if (rem_new == '0) begin
            res_nxt.finished = 1'b1;
            finished_nxt     = finished_r + CW'(1);
            state_nxt        = S_MET;
          end else begin
            state_nxt = S_OUT;
          end
        end else begin
          state_nxt = S_RUN_RD;
        end
      end

      S_JMP_RD: begin
        if (k_r >= loaded_r) begin
          sp_nxt    = '0;
          ran_nxt   = 1'b0;
          state_nxt = S_RUN_RD;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = k_r[IW-1:0];
          state_nxt = S_JMP_EV;
        end
      end

      S_JMP_EV: begin
        if (ram_rdata.remaining != '0) begin
          time_nxt  = TIME_W'(ram_rdata.arrival);
          sp_nxt    = '0;
          ran_nxt   = 1'b0;
          state_nxt = S_RUN_RD;
        end else begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_JMP_RD;
        end
      end

      S_MET: begin
        // time_r already holds the completion time
        res_nxt.resp_lat = ent_r.first_start - TIME_W'(ent_r.arrival);
        res_nxt.turn_lat = met_turn;
        res_nxt.wait_lat = met_turn - TIME_W'(ent_r.orig_len);
        state_nxt        = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      finished_r  <= '0;
      time_r      <= '0;
      sp_r        <= '0;
      ran_r       <= 1'b0;
      tslice_r    <= LEN_W'(1);
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      finished_r  <= finished_nxt;
      time_r      <= time_nxt;
      sp_r        <= sp_nxt;
      ran_r       <= ran_nxt;
      tslice_r    <= tslice_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ld_arr_r  <= ld_arr_nxt;
    ld_len_r  <= ld_len_nxt;
    ent_r     <= ent_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.status     = out_res_r.status;
  assign out_bus.job_id     = out_res_r.job_id;
  assign out_bus.start_time = out_res_r.start_time;
  assign out_bus.run_length = out_res_r.run_length;
  assign out_bus.finished   = out_res_r.finished;
  assign out_bus.resp_lat   = out_res_r.resp_lat;
  assign out_bus.turn_lat   = out_res_r.turn_lat;
  assign out_bus.wait_lat   = out_res_r.wait_lat;

  // table never overfills
  a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= CW'(MAX_JOBS))
    else $error("job count beyond table depth");

  // completions never outrun loads
  a_finished_bound: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r <= loaded_r)
    else $error("more jobs finished than loaded");

  // slice evaluation only looks at a loaded entry
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN_EV |-> sp_r < loaded_r)
    else $error("scan read past loaded entries");

  // sequencer never reads and writes the RAM in one cycle, so no forwarding is needed
  a_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("RAM read and write in the same cycle");

  // a completing slice bumps the finished count by one
  a_finish_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN_EV && run_hit && rem_new == '0) |=>
      finished_r == $past(finished_r) + CW'(1))
    else $error("finished count not advanced on completion");

endmodule

`default_nettype wire

[src/rrs_job_ram.sv]
// Job table RAM: one write port, one read port, read data registered.
// Depends on rrs_pkg for the entry type.
`default_nettype none

module rrs_job_ram #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  rrs_pkg::job_ent_t        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output rrs_pkg::job_ent_t        rdata
);
  import rrs_pkg::*;

  job_ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
